// ===== rtl/wsdfr_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
package wsdfr_pkg;

  localparam int unsigned LEN_W = 63;

  localparam logic [6:0] LEN_CODE_MAX7 = 7'd125;
  localparam logic [6:0] LEN_CODE_16   = 7'd126;
  localparam logic [3:0] OPC_PING      = 4'h9;

  localparam logic [LEN_W-1:0] EXT16_BYTES = LEN_W'(2);
  localparam logic [LEN_W-1:0] EXT64_BYTES = LEN_W'(8);

  typedef enum logic [4:0] {
    PH_FIRST  = 5'b00001,
    PH_SECOND = 5'b00010,
    PH_EXTLEN = 5'b00100,
    PH_KEY    = 5'b01000,
    PH_DATA   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic             vld;
    logic [7:0]       payload_byte;
    logic             has_byte;
    logic [3:0]       frame_opcode;
    logic             final_fragment;
    logic             is_ping;
    logic             was_masked;
    logic [LEN_W-1:0] frame_length;
    logic             last_in_frame;
  } rslt_t;

endpackage

// ===== rtl/wsdfr_parser.sv =====
// Header parser, length and mask tracking, and payload unmasking for one byte per cycle while byte_vld is high.
module wsdfr_parser
  import wsdfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] byte_in,
  output rslt_t      res
);

  phase_t           phase_r, phase_nxt;
  logic             fin_r, fin_nxt;
  logic [3:0]       opc_r, opc_nxt;
  logic             mask_r, mask_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [1:0]       pos_r, pos_nxt;

  logic             len_done;
  logic             start_pl;
  logic             emit;
  logic             emit_has;
  logic             emit_last;
  logic [7:0]       emit_data;
  logic [7:0]       key_byte;
  logic             rem_low;

  assign rem_low = (rem_r[LEN_W-1:1] == '0);

  // The first received key byte sits in the top of the shift register.
  always_comb begin
    case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    fin_nxt   = fin_r;
    opc_nxt   = opc_r;
    mask_nxt  = mask_r;
    len_nxt   = len_r;
    key_nxt   = key_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    len_done  = 1'b0;
    start_pl  = 1'b0;
    emit      = 1'b0;
    emit_has  = 1'b0;
    emit_last = 1'b0;
    emit_data = 8'd0;

    case (phase_r)
      PH_SECOND: begin
        mask_nxt = byte_in[7];
        key_nxt  = '0;
        if (byte_in[6:0] <= LEN_CODE_MAX7) begin
          len_nxt  = LEN_W'(byte_in[6:0]);
          len_done = 1'b1;
        end else begin
          len_nxt   = '0;
          rem_nxt   = (byte_in[6:0] == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
          phase_nxt = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        // Bits shifted past the top are dropped, which also clears the reserved top bit.
        len_nxt = {len_r[LEN_W-9:0], byte_in};
        if (rem_low) begin
          rem_nxt  = '0;
          len_done = 1'b1;
        end else begin
          rem_nxt = rem_r - LEN_W'(1);
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], byte_in};
        pos_nxt = pos_r + 2'd1;
        if (pos_nxt == 2'd0) begin
          start_pl = 1'b1;
        end
      end
      PH_DATA: begin
        emit_data = mask_r ? (byte_in ^ key_byte) : byte_in;
        pos_nxt   = pos_r + 2'd1;
        rem_nxt   = rem_low ? '0 : (rem_r - LEN_W'(1));
        emit      = 1'b1;
        emit_has  = 1'b1;
        emit_last = rem_low;
        if (rem_low) begin
          phase_nxt = PH_FIRST;
        end
      end
      default: begin
        fin_nxt   = byte_in[7];
        opc_nxt   = byte_in[3:0];
        phase_nxt = PH_SECOND;
      end
    endcase

    if (len_done) begin
      if (mask_nxt) begin
        pos_nxt   = 2'd0;
        phase_nxt = PH_KEY;
      end else begin
        start_pl = 1'b1;
      end
    end

    // A header that decodes to zero length closes the frame with an empty marker.
    if (start_pl) begin
      pos_nxt = 2'd0;
      if (len_nxt == '0) begin
        phase_nxt = PH_FIRST;
        emit      = 1'b1;
        emit_last = 1'b1;
      end else begin
        rem_nxt   = len_nxt;
        phase_nxt = PH_DATA;
      end
    end
  end

  always_comb begin
    res.vld            = byte_vld & emit;
    res.payload_byte   = emit_data;
    res.has_byte       = emit_has;
    res.frame_opcode   = opc_nxt;
    res.final_fragment = fin_nxt;
    res.is_ping        = (opc_nxt == OPC_PING);
    res.was_masked     = mask_nxt;
    res.frame_length   = len_nxt;
    res.last_in_frame  = emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      fin_r   <= 1'b0;
      opc_r   <= '0;
      mask_r  <= 1'b0;
      len_r   <= '0;
      key_r   <= '0;
      rem_r   <= '0;
      pos_r   <= '0;
    end else if (byte_vld) begin
      phase_r <= phase_nxt;
      fin_r   <= fin_nxt;
      opc_r   <= opc_nxt;
      mask_r  <= mask_nxt;
      len_r   <= len_nxt;
      key_r   <= key_nxt;
      rem_r   <= rem_nxt;
      pos_r   <= pos_nxt;
    end
  end

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld && !res.has_byte |-> res.last_in_frame && (res.frame_length == '0))
    else $error("empty-frame marker without last mark or with nonzero length");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld && res.last_in_frame |=> phase_r == PH_FIRST)
    else $error("parser did not return to the first header byte after a frame");

  a_ext_len: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld && (phase_r == PH_SECOND) && (byte_in[6:0] > LEN_CODE_MAX7)
    |=> (phase_r == PH_EXTLEN) && (rem_r == EXT16_BYTES || rem_r == EXT64_BYTES))
    else $error("extended length code did not start the length bytes");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld && (phase_r != PH_DATA) && (phase_nxt == PH_DATA) |=> rem_r != '0)
    else $error("payload phase entered with no bytes due");

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: handshakes and the result register.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   input    | in_valid, in_ready, in_byte             | in
//   result   | out_valid, out_ready, out_payload_byte, | out
//            | out_has_byte, out_frame_opcode,          |
//            | out_final_fragment, out_is_ping,         |
//            | out_was_masked, out_frame_length,        |
//            | out_last_in_frame                        |
//
// One byte is taken per cycle while in_ready is high; its result, if any, appears in
// the result register on the next cycle. Reset is synchronous and returns the parser
// to the first header byte. A stalled result register holds its request while the
// input waits; the input is ready whenever the register is empty or is being emptied
// in the same cycle.
module websocket_frame_deframer
  import wsdfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_payload_byte,
  output logic             out_has_byte,
  output logic [3:0]       out_frame_opcode,
  output logic             out_final_fragment,
  output logic             out_is_ping,
  output logic             out_was_masked,
  output logic [LEN_W-1:0] out_frame_length,
  output logic             out_last_in_frame
);

  rslt_t res;
  rslt_t out_r;
  logic  out_valid_r, out_valid_nxt;
  logic  in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  wsdfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_vld(in_fire),
    .byte_in (in_byte),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_has_byte       = out_r.has_byte;
  assign out_frame_opcode   = out_r.frame_opcode;
  assign out_final_fragment = out_r.final_fragment;
  assign out_is_ping        = out_r.is_ping;
  assign out_was_masked     = out_r.was_masked;
  assign out_frame_length   = out_r.frame_length;
  assign out_last_in_frame  = out_r.last_in_frame;

endmodule

// ===== sim/tb_websocket_frame_deframer.sv =====
// Self-checking testbench for the WebSocket frame deframer: queued byte stream, tracking predictor.
module tb_websocket_frame_deframer;
  import wsdfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  typedef enum int {LEN_FORM_7, LEN_FORM_16, LEN_FORM_64} len_form_t;

  typedef struct {
    logic [7:0] b;
    bit         drain;
  } stream_item_t;

  typedef struct {
    logic [7:0]       data;
    logic             has;
    logic [3:0]       opcode;
    logic             fin;
    logic             ping;
    logic             masked;
    logic [LEN_W-1:0] len;
    logic             last;
  } deframed_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_payload_byte;
  logic             out_has_byte;
  logic [3:0]       out_frame_opcode;
  logic             out_final_fragment;
  logic             out_is_ping;
  logic             out_was_masked;
  logic [LEN_W-1:0] out_frame_length;
  logic             out_last_in_frame;

  stream_item_t stream_q[$];
  deframed_t    deframed_q[$];
  int           n_queued = 0;
  int           n_results = 0;
  int           n_errors = 0;
  int           tx_gap = 0;
  bit           tx_steady = 1'b0;
  int           rx_wait = 0;
  bit           rx_steady = 1'b0;

  // Parser state tracked alongside the block.
  phase_t      rx_phase = PH_FIRST;
  logic        rx_fin = 1'b0;
  logic [3:0]  rx_opcode = 4'h0;
  logic        rx_masked = 1'b0;
  logic [63:0] rx_len = 64'd0;
  logic [31:0] rx_key = 32'd0;
  logic [63:0] rx_left = 64'd0;
  logic [1:0]  rx_key_pos = 2'd0;

  websocket_frame_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_has_byte      (out_has_byte),
    .out_frame_opcode  (out_frame_opcode),
    .out_final_fragment(out_final_fragment),
    .out_is_ping       (out_is_ping),
    .out_was_masked    (out_was_masked),
    .out_frame_length  (out_frame_length),
    .out_last_in_frame (out_last_in_frame)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic push_deframed(input logic [7:0] data, input logic has, input logic last);
    deframed_t r;
    r.data   = data;
    r.has    = has;
    r.opcode = rx_opcode;
    r.fin    = rx_fin;
    r.ping   = (rx_opcode == OPC_PING);
    r.masked = rx_masked;
    r.len    = rx_len[LEN_W-1:0];
    r.last   = last;
    deframed_q.push_back(r);
  endtask

  // A zero length closes the frame at once with an empty marker.
  task automatic begin_payload();
    rx_key_pos = 2'd0;
    if (rx_len == 64'd0) begin
      rx_phase = PH_FIRST;
      push_deframed(8'h00, 1'b0, 1'b1);
    end else begin
      rx_left  = rx_len;
      rx_phase = PH_DATA;
    end
  endtask

  task automatic finish_length();
    if (rx_masked) begin
      rx_key_pos = 2'd0;
      rx_phase   = PH_KEY;
    end else begin
      begin_payload();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] data;
    case (rx_phase)
      PH_SECOND: begin
        rx_masked = b[7];
        rx_key    = 32'd0;
        if (b[6:0] <= LEN_CODE_MAX7) begin
          rx_len = 64'(b[6:0]);
          finish_length();
        end else begin
          rx_len   = 64'd0;
          rx_left  = (b[6:0] == LEN_CODE_16) ? 64'd2 : 64'd8;
          rx_phase = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        rx_len = {rx_len[55:0], b};
        if (rx_left != 0) rx_left = rx_left - 1;
        if (rx_left == 0) begin
          rx_len[63] = 1'b0;
          finish_length();
        end
      end
      PH_KEY: begin
        rx_key     = {rx_key[23:0], b};
        rx_key_pos = rx_key_pos + 2'd1;
        if (rx_key_pos == 2'd0) begin_payload();
      end
      PH_DATA: begin
        data = rx_masked ? (b ^ rx_key[8 * (3 - int'(rx_key_pos)) +: 8]) : b;
        rx_key_pos = rx_key_pos + 2'd1;
        if (rx_left != 0) rx_left = rx_left - 1;
        if (rx_left == 0) rx_phase = PH_FIRST;
        push_deframed(data, 1'b1, rx_left == 0);
      end
      default: begin
        rx_fin    = b[7];
        rx_opcode = b[3:0];
        rx_phase  = PH_SECOND;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input bit drain);
    stream_item_t it;
    it.b     = b;
    it.drain = drain;
    stream_q.push_back(it);
    n_queued++;
  endtask

  task automatic add_frame(input bit fin, input logic [3:0] opcode, input bit masked,
                           input len_form_t form, input bit top_bit,
                           input int unsigned len, input bit drain_first);
    logic [63:0] ext;
    send_byte({fin, 3'($urandom), opcode}, drain_first);
    case (form)
      LEN_FORM_7: send_byte({masked, 7'(len)}, 1'b0);
      LEN_FORM_16: begin
        send_byte({masked, LEN_CODE_16}, 1'b0);
        send_byte(len[15:8], 1'b0);
        send_byte(len[7:0], 1'b0);
      end
      default: begin
        send_byte({masked, LEN_CODE_64}, 1'b0);
        ext = {top_bit, 31'd0, 32'(len)};
        for (int i = 7; i >= 0; i--) send_byte(ext[8*i +: 8], 1'b0);
      end
    endcase
    if (masked) repeat (4) send_byte(8'($urandom), 1'b0);
    repeat (len) send_byte(8'($urandom), 1'b0);
  endtask

  // Sender: one request in flight, a random gap after each accepted byte.
  always @(posedge clk) begin : drive
    stream_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && in_ready) deframe_byte(in_byte);
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          in_valid <= 1'b0;
          tx_gap   <= tx_gap - 1;
        end else if (stream_q.size() != 0 &&
                     !(stream_q[0].drain && deframed_q.size() != 0)) begin
          nxt = stream_q.pop_front();
          in_valid <= 1'b1;
          in_byte  <= nxt.b;
          if ($urandom_range(0, 39) == 0) tx_steady <= !tx_steady;
          tx_gap <= tx_steady ? 0 : $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each request against the oldest expectation, then stalls at random.
  always @(posedge clk) begin : watch
    deframed_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (deframed_q.size() == 0) begin
          report_mismatch("result with nothing expected", 64'(out_payload_byte), 64'd0);
        end else begin
          want = deframed_q.pop_front();
          if (out_payload_byte !== want.data)
            report_mismatch("payload_byte", 64'(out_payload_byte), 64'(want.data));
          if (out_has_byte !== want.has)
            report_mismatch("has_byte", 64'(out_has_byte), 64'(want.has));
          if (out_frame_opcode !== want.opcode)
            report_mismatch("frame_opcode", 64'(out_frame_opcode), 64'(want.opcode));
          if (out_final_fragment !== want.fin)
            report_mismatch("final_fragment", 64'(out_final_fragment), 64'(want.fin));
          if (out_is_ping !== want.ping)
            report_mismatch("is_ping", 64'(out_is_ping), 64'(want.ping));
          if (out_was_masked !== want.masked)
            report_mismatch("was_masked", 64'(out_was_masked), 64'(want.masked));
          if (out_frame_length !== want.len)
            report_mismatch("frame_length", 64'(out_frame_length), 64'(want.len));
          if (out_last_in_frame !== want.last)
            report_mismatch("last_in_frame", 64'(out_last_in_frame), 64'(want.last));
        end
        n_results++;
        // Two long hold-offs let the block fill up and push back on its input.
        if (n_results == 150 || n_results == 600) begin
          rx_wait = 80;
        end else begin
          if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
          rx_wait = rx_steady ? 0 : $urandom_range(0, 6);
        end
      end else if (rx_wait != 0) begin
        rx_wait = rx_wait - 1;
      end
      out_ready <= (rx_wait == 0);
    end
  end

  initial begin
    int unsigned len;
    int          pick;
    // Directed frames: empty frames in every length form, extreme lengths, the ignored
    // top length bit, non-minimal lengths and every opcode.
    add_frame(1'b1, 4'h1, 1'b0, LEN_FORM_7, 1'b0, 0, 1'b0);
    add_frame(1'b1, OPC_PING, 1'b1, LEN_FORM_7, 1'b0, 0, 1'b0);
    add_frame(1'b0, 4'h0, 1'b0, LEN_FORM_7, 1'b0, 1, 1'b0);
    add_frame(1'b1, 4'h2, 1'b1, LEN_FORM_7, 1'b0, 125, 1'b0);
    add_frame(1'b1, 4'h1, 1'b1, LEN_FORM_16, 1'b0, 0, 1'b0);
    add_frame(1'b0, 4'h2, 1'b0, LEN_FORM_16, 1'b0, 5, 1'b0);
    add_frame(1'b1, 4'h2, 1'b1, LEN_FORM_16, 1'b0, 258, 1'b0);
    add_frame(1'b1, 4'h8, 1'b0, LEN_FORM_64, 1'b0, 0, 1'b0);
    add_frame(1'b1, 4'h1, 1'b0, LEN_FORM_64, 1'b1, 0, 1'b0);
    add_frame(1'b1, 4'h1, 1'b1, LEN_FORM_64, 1'b1, 3, 1'b0);
    add_frame(1'b0, 4'h0, 1'b0, LEN_FORM_64, 1'b0, 7, 1'b0);
    for (int op = 0; op < 16; op++)
      add_frame(1'($urandom), 4'(op), 1'($urandom), LEN_FORM_7, 1'b0,
                $urandom_range(0, 2), 1'b0);
    add_frame(1'b1, 4'hA, 1'b1, LEN_FORM_7, 1'b0, 6, 1'b1);

    // Random well-formed frames, mostly short.
    while (n_queued < 1150) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
        if ($urandom_range(0, 19) == 0) len = $urandom_range(100, 125);
        add_frame(1'($urandom), 4'($urandom), 1'($urandom), LEN_FORM_7, 1'b0, len,
                  $urandom_range(0, 29) == 0);
      end else if (pick < 8) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 30);
        add_frame(1'($urandom), 4'($urandom), 1'($urandom), LEN_FORM_16, 1'b0, len,
                  $urandom_range(0, 29) == 0);
      end else begin
        add_frame(1'($urandom), 4'($urandom), 1'($urandom), LEN_FORM_64, 1'($urandom),
                  $urandom_range(0, 20), $urandom_range(0, 29) == 0);
      end
    end

    // Broken tail: truncated headers and raw noise, then a frame with a huge length
    // that the stream ends inside of.
    send_byte(8'h81, 1'b1);
    send_byte({1'b1, LEN_CODE_64}, 1'b0);
    send_byte(8'h00, 1'b0);
    repeat (40) send_byte(8'($urandom), 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte({1'b1, LEN_CODE_64}, 1'b0);
    send_byte(8'hFF, 1'b0);
    repeat (7) send_byte(8'($urandom), 1'b0);
    repeat (16) send_byte(8'($urandom), 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (stream_q.size() != 0 || in_valid) @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (deframed_q.size() != 0)
      report_mismatch("results never delivered", 64'(deframed_q.size()), 64'd0);
    if (n_errors == 0) begin
      $display("websocket_frame_deframer verification clean");
    end else begin
      $display("websocket_frame_deframer verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("websocket_frame_deframer verification failed");
    $finish;
  end

endmodule
